[rtl/atp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atp_pkg
// Shared types and character codes for the ASCII integer token parser.
// ----------------------------------------------------------------------------
package atp_pkg;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [2:0] {
    TK_SEP,
    TK_EOL,
    TK_HASH,
    TK_PLUS,
    TK_MINUS,
    TK_DIGIT,
    TK_OTHER
  } tok_kind_t;

  typedef struct packed {
    logic      eod;
    tok_kind_t kind;
    logic [3:0] digit;
  } tok_t;

  localparam int TokWidth = $bits(tok_t);

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_COMMENT = 2'd1,
    MODE_SIGN    = 2'd2,
    MODE_NUMBER  = 2'd3
  } scan_mode_t;

endpackage

[rtl/atp_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atp_fifo
// Small synchronous queue with registered storage and count-based flags.
// ----------------------------------------------------------------------------
module atp_fifo #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [Width-1:0] data_in,
  output logic             full,
  input  logic             pop,
  output logic [Width-1:0] data_out,
  output logic             empty
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  logic [Width-1:0] mem [Depth];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CW'(Depth));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign data_out = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= data_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/atp_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atp_front
// Byte classifier: turns each input word into a token for the scanner.
// ----------------------------------------------------------------------------
module atp_front (
  input  logic [7:0]   text_byte,
  input  logic         end_of_data,
  output atp_pkg::tok_t tok
);

  atp_pkg::tok_kind_t kind;

  always_comb begin
    priority if (text_byte == atp_pkg::CH_LF || text_byte == atp_pkg::CH_CR) begin
      kind = atp_pkg::TK_EOL;
    end else if (text_byte == atp_pkg::CH_SPACE || text_byte == atp_pkg::CH_TAB ||
                 text_byte == atp_pkg::CH_COMMA) begin
      kind = atp_pkg::TK_SEP;
    end else if (text_byte == atp_pkg::CH_HASH) begin
      kind = atp_pkg::TK_HASH;
    end else if (text_byte == atp_pkg::CH_PLUS) begin
      kind = atp_pkg::TK_PLUS;
    end else if (text_byte == atp_pkg::CH_MINUS) begin
      kind = atp_pkg::TK_MINUS;
    end else if (text_byte >= atp_pkg::CH_ZERO && text_byte <= atp_pkg::CH_NINE) begin
      kind = atp_pkg::TK_DIGIT;
    end else begin
      kind = atp_pkg::TK_OTHER;
    end
  end

  assign tok.eod   = end_of_data;
  assign tok.kind  = kind;
  assign tok.digit = text_byte[3:0];

endmodule

[rtl/atp_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atp_back
// Token scanner: tracks mode, sign and saturating magnitude, emits numbers.
// ----------------------------------------------------------------------------
module atp_back #(
  parameter int ValueWidth = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_empty,
  input  atp_pkg::tok_t         cmd_data,
  output logic                  cmd_pop,
  input  logic                  res_full,
  output logic                  res_push,
  output logic [ValueWidth+2:0] res_data
);

  localparam int SW = ValueWidth + 4;
  localparam logic [ValueWidth-1:0] Half = {1'b1, {(ValueWidth - 1){1'b0}}};

  atp_pkg::scan_mode_t scan_mode;
  atp_pkg::scan_mode_t scan_mode_next;
  logic                  is_negative;
  logic                  is_negative_next;
  logic [ValueWidth-1:0] magnitude;
  logic [ValueWidth-1:0] magnitude_next;
  logic                  saturated;
  logic                  saturated_next;

  logic                  go;
  logic                  is_digit;
  logic [SW-1:0]         mag_ext;
  logic [SW-1:0]         acc;
  logic [ValueWidth-1:0] limit;
  logic                  emit;
  logic                  found;
  logic [ValueWidth-1:0] value;

  assign go       = !cmd_empty && !res_full;
  assign cmd_pop  = go;
  assign is_digit = (cmd_data.kind == atp_pkg::TK_DIGIT);
  assign mag_ext  = SW'(magnitude);
  assign acc      = (mag_ext << 3) + (mag_ext << 1) + SW'(cmd_data.digit);
  assign limit    = is_negative ? Half : Half - 1'b1;

  // next mode
  always_comb begin
    scan_mode_next = scan_mode;
    if (cmd_data.eod) begin
      scan_mode_next = atp_pkg::MODE_IDLE;
    end else begin
      unique case (scan_mode)
        atp_pkg::MODE_IDLE: begin
          unique case (cmd_data.kind)
            atp_pkg::TK_HASH:  scan_mode_next = atp_pkg::MODE_COMMENT;
            atp_pkg::TK_PLUS,
            atp_pkg::TK_MINUS: scan_mode_next = atp_pkg::MODE_SIGN;
            atp_pkg::TK_DIGIT: scan_mode_next = atp_pkg::MODE_NUMBER;
            default:           scan_mode_next = atp_pkg::MODE_IDLE;
          endcase
        end
        atp_pkg::MODE_COMMENT: begin
          if (cmd_data.kind == atp_pkg::TK_EOL) begin
            scan_mode_next = atp_pkg::MODE_IDLE;
          end
        end
        atp_pkg::MODE_SIGN: begin
          scan_mode_next = is_digit ? atp_pkg::MODE_NUMBER : atp_pkg::MODE_IDLE;
        end
        atp_pkg::MODE_NUMBER: begin
          scan_mode_next = is_digit ? atp_pkg::MODE_NUMBER : atp_pkg::MODE_IDLE;
        end
        default: scan_mode_next = atp_pkg::MODE_IDLE;
      endcase
    end
  end

  // sign and magnitude
  always_comb begin
    is_negative_next = is_negative;
    magnitude_next   = magnitude;
    saturated_next   = saturated;
    if (cmd_data.eod) begin
      is_negative_next = 1'b0;
      magnitude_next   = '0;
      saturated_next   = 1'b0;
    end else begin
      unique case (scan_mode)
        atp_pkg::MODE_IDLE: begin
          if (cmd_data.kind == atp_pkg::TK_PLUS) begin
            is_negative_next = 1'b0;
          end else if (cmd_data.kind == atp_pkg::TK_MINUS) begin
            is_negative_next = 1'b1;
          end else if (is_digit) begin
            is_negative_next = 1'b0;
            magnitude_next   = ValueWidth'(cmd_data.digit);
            saturated_next   = 1'b0;
          end
        end
        atp_pkg::MODE_COMMENT: begin
        end
        atp_pkg::MODE_SIGN: begin
          if (is_digit) begin
            magnitude_next = ValueWidth'(cmd_data.digit);
            saturated_next = 1'b0;
          end else begin
            is_negative_next = 1'b0;
          end
        end
        atp_pkg::MODE_NUMBER: begin
          if (is_digit) begin
            if (acc > SW'(limit)) begin
              magnitude_next = limit;
              saturated_next = 1'b1;
            end else begin
              magnitude_next = acc[ValueWidth-1:0];
            end
          end else begin
            is_negative_next = 1'b0;
            magnitude_next   = '0;
            saturated_next   = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // result word
  always_comb begin
    found = (scan_mode == atp_pkg::MODE_NUMBER);
    emit  = cmd_data.eod || (found && !is_digit);
    value = '0;
    if (found) begin
      value = is_negative ? ('0 - magnitude) : magnitude;
    end
    res_push = go && emit;
    res_data = {value, found, found && saturated, cmd_data.eod};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode   <= atp_pkg::MODE_IDLE;
      is_negative <= 1'b0;
      magnitude   <= '0;
      saturated   <= 1'b0;
    end else if (go) begin
      scan_mode   <= scan_mode_next;
      is_negative <= is_negative_next;
      magnitude   <= magnitude_next;
      saturated   <= saturated_next;
    end
  end

endmodule

[rtl/ascii_integer_token_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_integer_token_parser
// Pulls signed, saturating decimal integers out of a byte stream.
// A result word passes through the command and result queues before a pop.
// Throughput: one input word per cycle while the result queue is not full.
// Two-entry queues sit between classifier, scanner and result port.
// Reset: synchronous rst empties both queues and returns the scanner to idle.
// ----------------------------------------------------------------------------
module ascii_integer_token_parser #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  output logic                   full,
  input  logic [7:0]             text_byte,
  input  logic                   end_of_data,
  output logic                   empty,
  input  logic                   pop,
  output logic signed [VALUE_WIDTH-1:0] number_value,
  output logic                   number_found,
  output logic                   overflowed,
  output logic                   stream_done
);

  localparam int ResWidth = VALUE_WIDTH + 3;

  atp_pkg::tok_t               tok_in;
  logic [atp_pkg::TokWidth-1:0] cmd_bits;
  atp_pkg::tok_t               cmd_data;
  logic                        cmd_empty;
  logic                        cmd_pop;
  logic                        res_full;
  logic                        res_push;
  logic [ResWidth-1:0]         res_in;
  logic [ResWidth-1:0]         res_out;

  atp_front u_front (
    .text_byte   (text_byte),
    .end_of_data (end_of_data),
    .tok         (tok_in)
  );

  atp_fifo #(
    .Width (atp_pkg::TokWidth),
    .Depth (2)
  ) u_cmd_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .data_in  (tok_in),
    .full     (full),
    .pop      (cmd_pop),
    .data_out (cmd_bits),
    .empty    (cmd_empty)
  );

  assign cmd_data = atp_pkg::tok_t'(cmd_bits);

  atp_back #(
    .ValueWidth (VALUE_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cmd_empty),
    .cmd_data  (cmd_data),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_data  (res_in)
  );

  atp_fifo #(
    .Width (ResWidth),
    .Depth (2)
  ) u_res_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (res_push),
    .data_in  (res_in),
    .full     (res_full),
    .pop      (pop),
    .data_out (res_out),
    .empty    (empty)
  );

  assign number_value = res_out[ResWidth-1:3];
  assign number_found = res_out[2];
  assign overflowed   = res_out[1];
  assign stream_done  = res_out[0];

endmodule
